// ===== rtl/core/gcw_pkg.sv =====
// ----------------------------------------------------------------------------
// gcw_pkg
// Shared types and constants of the generalized cosine window generator.
// ----------------------------------------------------------------------------
package gcw_pkg;

    localparam int MAX_LENGTH = 4096;
    localparam int MAX_TERMS  = 5;
    localparam int FRAC_BITS  = 16;

    localparam int IDX_W     = 12;
    localparam int LEN_W     = 13;
    localparam int PER_W     = 13;
    localparam int TERM_W    = 3;
    localparam int COEF_W    = 18;
    localparam int OUT_W     = 18;
    localparam int CFG_IDX_W = 3;
    localparam int M_W       = IDX_W + 2;
    localparam int Q_W       = 30;
    localparam int T_W       = 31;
    localparam int COS_W     = 32;
    localparam int NUM_W     = 44;
    localparam int PROD_W    = COEF_W + COS_W;
    localparam int ACC_W     = 52;

    localparam logic [T_W-1:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [T_W-1:0] HALF_PI_Q30 = 31'd1686629713;

    localparam int OUT_MAX = 131071;
    localparam int OUT_MIN = -131072;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(OUT_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(OUT_MIN);
    localparam logic signed [OUT_W-1:0] UNITY =
        OUT_W'((FRAC_BITS >= OUT_W - 1) ? OUT_MAX : (1 << FRAC_BITS));

    // Horner divisors of the cosine and sine series.
    localparam int POLY_STEPS = 4;
    localparam int COS_DIV [POLY_STEPS] = '{56, 30, 12, 2};
    localparam int SIN_DIV [POLY_STEPS] = '{72, 42, 20, 6};

    // Lane timing.
    localparam int STEP_LAT = 3;
    localparam int QUAD_LAT = 2;
    localparam int X_DLY    = 2 + POLY_STEPS * STEP_LAT;
    localparam int SWQ_DLY  = Q_W + X_DLY + 2;
    localparam int LANE_LAT = 1 + M_W + QUAD_LAT + 1 + Q_W + X_DLY + 2;

    localparam logic [LEN_W-1:0]  RST_WINDOW_LENGTH = 13'd1024;
    localparam logic              RST_SYMMETRIC     = 1'b0;
    localparam logic [TERM_W-1:0] RST_TERM_COUNT    = 3'd2;
    localparam logic signed [COEF_W-1:0] RST_COEF_ZERO = 18'sd32768;
    localparam logic signed [COEF_W-1:0] RST_COEF_ONE  = -18'sd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LENGTH = 3'd0,
        CFG_SYMMETRIC     = 3'd1,
        CFG_TERM_COUNT    = 3'd2,
        CFG_COEF_ZERO     = 3'd3,
        CFG_COEF_ONE      = 3'd4,
        CFG_COEF_TWO      = 3'd5,
        CFG_COEF_THREE    = 3'd6,
        CFG_COEF_FOUR     = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic             ce;
        logic [PER_W-1:0] period;
    } t_pipe_ctl;

endpackage

// ===== rtl/core/gcw_udiv.sv =====
// ----------------------------------------------------------------------------
// gcw_udiv
// Pipelined restoring divider by the window period, one quotient bit a stage.
// ----------------------------------------------------------------------------
module gcw_udiv #(
    parameter int QUO_W = 2
) (
    input  logic                    i_clk,
    input  gcw_pkg::t_pipe_ctl      i_ctl,
    input  logic [gcw_pkg::PER_W-1:0] i_rem_init,
    input  logic [QUO_W-1:0]        i_bits,
    output logic [QUO_W-1:0]        o_quo,
    output logic [gcw_pkg::PER_W-1:0] o_rem
);

    logic [gcw_pkg::PER_W-1:0] r_rem  [QUO_W];
    logic [QUO_W-1:0]          r_quo  [QUO_W];
    logic [QUO_W-1:0]          r_bits [QUO_W-1];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic [gcw_pkg::PER_W-1:0] w_rem_in;
        logic [QUO_W-1:0]          w_bits_in;
        logic [QUO_W-1:0]          w_quo_in;
        logic [gcw_pkg::PER_W:0]   w_trial;
        logic                      w_fit;

        if (k == 0) begin : g_first
            assign w_rem_in  = i_rem_init;
            assign w_bits_in = i_bits;
            assign w_quo_in  = '0;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_bits_in = r_bits[k-1];
            assign w_quo_in  = r_quo[k-1];
        end

        assign w_trial = {w_rem_in, w_bits_in[QUO_W-1]};
        assign w_fit   = (w_trial >= {1'b0, i_ctl.period});

        always_ff @(posedge i_clk) begin
            if (i_ctl.ce) begin
                r_rem[k] <= w_fit ? gcw_pkg::PER_W'(w_trial - {1'b0, i_ctl.period})
                                  : w_trial[gcw_pkg::PER_W-1:0];
                r_quo[k] <= {w_quo_in[QUO_W-2:0], w_fit};
            end
        end

        if (k < QUO_W - 1) begin : g_bits
            always_ff @(posedge i_clk) begin
                if (i_ctl.ce) begin
                    r_bits[k] <= w_bits_in << 1;
                end
            end
        end
    end

    assign o_quo = r_quo[QUO_W-1];
    assign o_rem = r_rem[QUO_W-1];

endmodule

// ===== rtl/core/gcw_poly_step.sv =====
// ----------------------------------------------------------------------------
// gcw_poly_step
// One Horner step t' = 1 - ((x2 * t) >> 30) / DIVISOR, three stages.
// ----------------------------------------------------------------------------
module gcw_poly_step #(
    parameter int DIVISOR = 56
) (
    input  logic                      i_clk,
    input  logic                      i_ce,
    input  logic [gcw_pkg::Q_W-1:0]   i_x2,
    input  logic [gcw_pkg::T_W-1:0]   i_t,
    output logic [gcw_pkg::Q_W-1:0]   o_x2,
    output logic [gcw_pkg::T_W-1:0]   o_t
);

    // Reciprocal underestimates the quotient by at most one.
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DIVISOR);
    localparam logic [7:0]  DIV_C = 8'(DIVISOR);

    logic [60:0] r_prod;
    logic [29:0] r_x2_a, r_x2_b, r_v;
    logic [61:0] r_m;
    logic [29:0] w_q_est, w_rem, w_q;
    logic [37:0] w_qd;

    assign w_q_est = r_m[61:32];
    assign w_qd    = 38'(w_q_est) * 38'(DIV_C);
    assign w_rem   = r_v - w_qd[29:0];
    assign w_q     = (w_rem >= 30'(DIV_C)) ? w_q_est + 30'd1 : w_q_est;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_prod <= 61'(i_x2) * 61'(i_t);
            r_x2_a <= i_x2;
            r_v    <= r_prod[59:30];
            r_m    <= 62'(r_prod[59:30]) * 62'(RECIP);
            r_x2_b <= r_x2_a;
            o_t    <= gcw_pkg::Q30_ONE - {1'b0, w_q};
            o_x2   <= r_x2_b;
        end
    end

endmodule

// ===== rtl/core/gcw_lane.sv =====
// ----------------------------------------------------------------------------
// gcw_lane
// Cosine of one harmonic: reduction, angle division, series and sign.
// ----------------------------------------------------------------------------
module gcw_lane #(
    parameter int HARMONIC = 1
) (
    input  logic                            i_clk,
    input  gcw_pkg::t_pipe_ctl              i_ctl,
    input  logic [gcw_pkg::IDX_W-1:0]       i_idx,
    output logic signed [gcw_pkg::COS_W-1:0] o_cos
);

    localparam int PW = gcw_pkg::PER_W;
    localparam int QW = gcw_pkg::Q_W;
    localparam int TW = gcw_pkg::T_W;
    localparam int NW = gcw_pkg::NUM_W;

    logic [gcw_pkg::M_W-1:0] r_m;
    logic [PW-1:0] w_p, w_r, w_rr;
    logic [1:0]    w_quad;
    logic          w_swap;
    logic [NW-1:0] r_num;
    logic          r_sw_d   [gcw_pkg::SWQ_DLY];
    logic [1:0]    r_quad_d [gcw_pkg::SWQ_DLY];
    logic [QW-1:0] w_x;
    logic [QW-1:0] r_x_d [gcw_pkg::X_DLY];
    logic [59:0]   r_xx;
    logic [QW-1:0] r_x2;
    logic [QW-1:0] w_x2 [gcw_pkg::POLY_STEPS];
    logic [TW-1:0] w_ct [gcw_pkg::POLY_STEPS+1];
    logic [TW-1:0] w_st [gcw_pkg::POLY_STEPS+1];
    logic [TW-1:0] r_sin, r_cos_d, w_cq, w_sq;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ce) begin
            r_m <= gcw_pkg::M_W'(i_idx) * gcw_pkg::M_W'(HARMONIC);
        end
    end

    // p = (i * j) mod period
    gcw_udiv #(.QUO_W(gcw_pkg::M_W)) u_mod (
        .i_clk(i_clk), .i_ctl(i_ctl), .i_rem_init('0), .i_bits(r_m),
        .o_quo(), .o_rem(w_p)
    );

    // 4p divided by the period gives the quadrant and the remainder.
    gcw_udiv #(.QUO_W(gcw_pkg::QUAD_LAT)) u_quad (
        .i_clk(i_clk), .i_ctl(i_ctl), .i_rem_init(w_p), .i_bits(2'b00),
        .o_quo(w_quad), .o_rem(w_r)
    );

    assign w_swap = ({w_r, 1'b0} > {1'b0, i_ctl.period});
    assign w_rr   = w_swap ? i_ctl.period - w_r : w_r;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ce) begin
            r_num <= NW'(w_rr) * NW'(gcw_pkg::HALF_PI_Q30) + NW'(i_ctl.period >> 1);
            r_sw_d[0]   <= w_swap;
            r_quad_d[0] <= w_quad;
            for (int k = 1; k < gcw_pkg::SWQ_DLY; k++) begin
                r_sw_d[k]   <= r_sw_d[k-1];
                r_quad_d[k] <= r_quad_d[k-1];
            end
        end
    end

    // Angle in Q30, rounded to nearest.
    gcw_udiv #(.QUO_W(QW)) u_angle (
        .i_clk(i_clk), .i_ctl(i_ctl), .i_rem_init(PW'(r_num[NW-1:QW])),
        .i_bits(r_num[QW-1:0]), .o_quo(w_x), .o_rem()
    );

    always_ff @(posedge i_clk) begin
        if (i_ctl.ce) begin
            r_xx     <= 60'(w_x) * 60'(w_x);
            r_x2     <= QW'((r_xx + 60'(1 << 29)) >> 30);
            r_x_d[0] <= w_x;
            for (int k = 1; k < gcw_pkg::X_DLY; k++) begin
                r_x_d[k] <= r_x_d[k-1];
            end
        end
    end

    assign w_x2[0] = r_x2;
    assign w_ct[0] = gcw_pkg::Q30_ONE;
    assign w_st[0] = gcw_pkg::Q30_ONE;

    for (genvar k = 0; k < gcw_pkg::POLY_STEPS; k++) begin : g_poly
        if (k < gcw_pkg::POLY_STEPS - 1) begin : g_mid
            gcw_poly_step #(.DIVISOR(gcw_pkg::COS_DIV[k])) u_cos (
                .i_clk(i_clk), .i_ce(i_ctl.ce), .i_x2(w_x2[k]), .i_t(w_ct[k]),
                .o_x2(w_x2[k+1]), .o_t(w_ct[k+1])
            );
        end else begin : g_last
            gcw_poly_step #(.DIVISOR(gcw_pkg::COS_DIV[k])) u_cos (
                .i_clk(i_clk), .i_ce(i_ctl.ce), .i_x2(w_x2[k]), .i_t(w_ct[k]),
                .o_x2(), .o_t(w_ct[k+1])
            );
        end
        // The sine chain runs in step with the cosine chain and shares its x2.
        gcw_poly_step #(.DIVISOR(gcw_pkg::SIN_DIV[k])) u_sin (
            .i_clk(i_clk), .i_ce(i_ctl.ce), .i_x2(w_x2[k]), .i_t(w_st[k]),
            .o_x2(), .o_t(w_st[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ce) begin
            r_sin <= TW'((61'(r_x_d[gcw_pkg::X_DLY-1]) *
                          61'(w_st[gcw_pkg::POLY_STEPS])) >> 30);
            r_cos_d <= w_ct[gcw_pkg::POLY_STEPS];
        end
    end

    assign w_cq = r_sw_d[gcw_pkg::SWQ_DLY-1] ? r_sin : r_cos_d;
    assign w_sq = r_sw_d[gcw_pkg::SWQ_DLY-1] ? r_cos_d : r_sin;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ce) begin
            unique case (r_quad_d[gcw_pkg::SWQ_DLY-1])
                2'd0: o_cos <= $signed({1'b0, w_cq});
                2'd1: o_cos <= -$signed({1'b0, w_sq});
                2'd2: o_cos <= -$signed({1'b0, w_cq});
                default: o_cos <= $signed({1'b0, w_sq});
            endcase
        end
    end

endmodule

// ===== rtl/core/generalized_cosine_window_gen_core.sv =====
// ----------------------------------------------------------------------------
// generalized_cosine_window_gen_core
// Window coefficient generator: w[i] = sum of c_j * cos(2*pi*i*j/L), Q2.16.
//
// Each accepted sample_index word yields one window_value word, in order.
// It takes one word per clock while the skid register is empty; most of
// its stages lie in the per-harmonic lanes, chiefly the 14-stage index
// reduction and the 30-stage angle divider (one quotient bit per stage)
// followed by the four-step cosine and sine series. Four lanes run side by
// side for harmonics one to four; the constant term needs no lane. L is
// window_length (capped at 4096) minus one when symmetric is set, else the
// capped length; a window length of zero or one returns exactly 1.0. The
// sum is rounded half up and saturated to the signed 18-bit range. A skid
// register holds one result while the output waits. Configuration registers
// must be written only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module generalized_cosine_window_gen_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [gcw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gcw_pkg::COEF_W-1:0]       i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [gcw_pkg::IDX_W-1:0]        i_sample_index,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [gcw_pkg::OUT_W-1:0] o_window_value
);

    localparam int NLANE = gcw_pkg::MAX_TERMS - 1;

    // Configuration registers.
    logic [gcw_pkg::LEN_W-1:0]         r_window_length;
    logic                              r_symmetric;
    logic [gcw_pkg::TERM_W-1:0]        r_term_count;
    logic signed [gcw_pkg::COEF_W-1:0] r_coef [gcw_pkg::MAX_TERMS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= gcw_pkg::RST_WINDOW_LENGTH;
            r_symmetric     <= gcw_pkg::RST_SYMMETRIC;
            r_term_count    <= gcw_pkg::RST_TERM_COUNT;
            r_coef[0]       <= gcw_pkg::RST_COEF_ZERO;
            r_coef[1]       <= gcw_pkg::RST_COEF_ONE;
            r_coef[2]       <= '0;
            r_coef[3]       <= '0;
            r_coef[4]       <= '0;
        end else if (i_cfg_we) begin
            unique case (gcw_pkg::t_cfg_reg'(i_cfg_index))
                gcw_pkg::CFG_WINDOW_LENGTH: r_window_length <= i_cfg_data[12:0];
                gcw_pkg::CFG_SYMMETRIC:     r_symmetric     <= i_cfg_data[0];
                gcw_pkg::CFG_TERM_COUNT:    r_term_count    <= i_cfg_data[2:0];
                gcw_pkg::CFG_COEF_ZERO:     r_coef[0]       <= $signed(i_cfg_data);
                gcw_pkg::CFG_COEF_ONE:      r_coef[1]       <= $signed(i_cfg_data);
                gcw_pkg::CFG_COEF_TWO:      r_coef[2]       <= $signed(i_cfg_data);
                gcw_pkg::CFG_COEF_THREE:    r_coef[3]       <= $signed(i_cfg_data);
                default:                    r_coef[4]       <= $signed(i_cfg_data);
            endcase
        end
    end

    // Values derived from configuration. Every stage reads them directly; the user
    // must keep them still while words are in flight, as the block does not enforce it.
    logic [gcw_pkg::LEN_W-1:0]  w_len;
    logic [gcw_pkg::PER_W-1:0]  w_period;
    logic [gcw_pkg::TERM_W-1:0] w_terms;
    logic                       w_short;

    assign w_len    = (r_window_length > gcw_pkg::LEN_W'(gcw_pkg::MAX_LENGTH))
                    ? gcw_pkg::LEN_W'(gcw_pkg::MAX_LENGTH) : r_window_length;
    assign w_period = r_symmetric ? w_len - 13'd1 : w_len;
    assign w_terms  = (r_term_count > gcw_pkg::TERM_W'(gcw_pkg::MAX_TERMS))
                    ? gcw_pkg::TERM_W'(gcw_pkg::MAX_TERMS) : r_term_count;
    assign w_short  = (r_window_length <= 13'd1);

    // Flow control: the whole pipeline advances unless the skid register is
    // holding a word, which guarantees room for whatever reaches the end.
    logic                       r_skid_valid;
    logic signed [gcw_pkg::OUT_W-1:0] r_skid_data;
    logic                       w_ce, w_accept;
    gcw_pkg::t_pipe_ctl         w_ctl;

    assign w_ce       = !r_skid_valid;
    assign o_in_ready = w_ce;
    assign w_accept   = i_in_valid && w_ce;
    assign w_ctl.ce     = w_ce;
    assign w_ctl.period = w_period;

    // Valid bits follow the words through the lanes and the final stages.
    logic [gcw_pkg::LANE_LAT-1:0] r_vld;
    logic r_vld_prod, r_vld_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_vld_prod <= 1'b0;
            r_vld_acc  <= 1'b0;
        end else if (w_ce) begin
            r_vld      <= {r_vld[gcw_pkg::LANE_LAT-2:0], w_accept};
            r_vld_prod <= r_vld[gcw_pkg::LANE_LAT-1];
            r_vld_acc  <= r_vld_prod;
        end
    end

    // One cosine lane per harmonic above zero.
    logic signed [gcw_pkg::COS_W-1:0] w_cos [NLANE];

    for (genvar g = 0; g < NLANE; g++) begin : g_lane
        gcw_lane #(.HARMONIC(g + 1)) u_lane (
            .i_clk(i_clk), .i_ctl(w_ctl), .i_idx(i_sample_index), .o_cos(w_cos[g])
        );
    end

    // Weight each harmonic; terms beyond the term count contribute zero.
    logic signed [gcw_pkg::PROD_W-1:0] r_prod [NLANE];

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int j = 0; j < NLANE; j++) begin
                r_prod[j] <= (gcw_pkg::TERM_W'(j + 1) < w_terms)
                           ? gcw_pkg::PROD_W'(r_coef[j+1]) * gcw_pkg::PROD_W'(w_cos[j])
                           : '0;
            end
        end
    end

    // The constant term is c0 times exactly 1.0 in Q30.
    logic signed [gcw_pkg::ACC_W-1:0] w_sum, r_acc;

    always_comb begin
        w_sum = (w_terms != '0) ? (gcw_pkg::ACC_W'(r_coef[0]) <<< 30) : '0;
        for (int j = 0; j < NLANE; j++) begin
            w_sum = w_sum + gcw_pkg::ACC_W'(r_prod[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_acc <= w_sum;
        end
    end

    // Round half up by 30 bits, saturate, or force 1.0 for a window of length zero or one.
    logic signed [gcw_pkg::ACC_W-1:0] w_rnd;
    logic signed [gcw_pkg::OUT_W-1:0] w_result;

    assign w_rnd = (r_acc + gcw_pkg::ACC_W'(1 << 29)) >>> 30;

    always_comb begin
        if (w_short) begin
            w_result = gcw_pkg::UNITY;
        end else if (w_rnd > gcw_pkg::SAT_HI) begin
            w_result = gcw_pkg::OUT_W'(gcw_pkg::OUT_MAX);
        end else if (w_rnd < gcw_pkg::SAT_LO) begin
            w_result = gcw_pkg::OUT_W'(gcw_pkg::OUT_MIN);
        end else begin
            w_result = w_rnd[gcw_pkg::OUT_W-1:0];
        end
    end

    // Output register with a skid register behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!o_out_valid || i_out_ready) begin
            if (r_skid_valid) begin
                o_window_value <= r_skid_data;
                o_out_valid    <= 1'b1;
                r_skid_valid   <= 1'b0;
            end else if (w_ce && r_vld_acc) begin
                o_window_value <= w_result;
                o_out_valid    <= 1'b1;
            end else begin
                o_out_valid    <= 1'b0;
            end
        end else if (w_ce && r_vld_acc) begin
            r_skid_data  <= w_result;
            r_skid_valid <= 1'b1;
        end
    end

endmodule

// ===== rtl/core/gcw_checker.sv =====
// ----------------------------------------------------------------------------
// gcw_checker
// Port-level checks of the window generator, bound to the top level.
// ----------------------------------------------------------------------------
module gcw_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_in_ready,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic signed [gcw_pkg::OUT_W-1:0] o_window_value
);

    // A result word that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_window_value))
        else $error("output word changed while stalled");

    // Input back-pressure only comes from a full output side.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no word waiting at the output");

    // Once the consumer takes a word, the skid drains and input reopens.
    a_stall_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready && i_out_ready |=> o_in_ready)
        else $error("input stayed stalled after the output was taken");

endmodule

bind generalized_cosine_window_gen_core gcw_checker u_gcw_checker (.*);

// ===== bench/tb_generalized_cosine_window_gen_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_generalized_cosine_window_gen_core
// Self-checking bench for the cosine window generator. A queue-fed driver
// sends sample index words, a monitor compares each window value against an
// in-bench fixed-point model, and the run sweeps several window setups under
// varying amounts of idling and back-pressure on both channels.
// ----------------------------------------------------------------------------
module tb_generalized_cosine_window_gen_core;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int DRAIN_CYCLES = 200;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_we = 1'b0;
    logic [gcw_pkg::CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [gcw_pkg::COEF_W-1:0]        i_cfg_data = '0;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_ready;
    logic [gcw_pkg::IDX_W-1:0]         i_sample_index = '0;
    logic                              o_out_valid;
    logic                              i_out_ready = 1'b0;
    logic signed [gcw_pkg::OUT_W-1:0]  o_window_value;

    generalized_cosine_window_gen_core dut (.*);

    always #10 i_clk = ~i_clk;

    // Local copy of the window setup, updated together with each write.
    logic [12:0]                        win_len;
    logic                               win_sym;
    logic [2:0]                         win_terms;
    logic signed [gcw_pkg::COEF_W-1:0]  win_coef [5];

    logic [gcw_pkg::IDX_W-1:0]          index_queue [$];
    logic signed [gcw_pkg::OUT_W-1:0]   window_expected [$];

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  send_hold = 1'b0;
    int  error_count = 0;
    int  cycle_count = 0;

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0d: %s", cycle_count, what);
        error_count++;
    endtask

    // cos(2*pi*p/period) in signed Q30, built from quadrant reduction and
    // truncating Horner series for sine and cosine on the reduced angle.
    function automatic longint cos_of_turn(longint unsigned p, longint unsigned period);
        longint unsigned q, quad, r, rr, x, x2, t, c, s;
        bit              swap;
        longint          cq, sq;
        q    = 4 * p;
        quad = (q / period) & 3;
        r    = q % period;
        swap = (2 * r > period);
        rr   = swap ? period - r : r;
        x    = (rr * 64'd1686629713 + period / 2) / period;
        x2   = (x * x + (64'd1 << 29)) >> 30;
        t = (64'd1 << 30) - x2 / 56;
        t = (64'd1 << 30) - ((x2 * t) >> 30) / 30;
        t = (64'd1 << 30) - ((x2 * t) >> 30) / 12;
        c = (64'd1 << 30) - ((x2 * t) >> 30) / 2;
        t = (64'd1 << 30) - x2 / 72;
        t = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
        t = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
        t = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
        s = (x * t) >> 30;
        cq = swap ? longint'(s) : longint'(c);
        sq = swap ? longint'(c) : longint'(s);
        case (quad)
            0: return cq;
            1: return -sq;
            2: return -cq;
            default: return sq;
        endcase
    endfunction

    function automatic logic signed [gcw_pkg::OUT_W-1:0] window_at(
        logic [gcw_pkg::IDX_W-1:0] idx);
        longint unsigned n, terms, period, u;
        longint          acc, res;
        n     = (win_len > 4096) ? 4096 : win_len;
        terms = (win_terms > 5) ? 5 : win_terms;
        if (n <= 1) begin
            res = 1 << gcw_pkg::FRAC_BITS;
        end else begin
            period = win_sym ? n - 1 : n;
            acc = 0;
            for (int j = 0; j < terms; j++)
                acc += longint'(win_coef[j]) * cos_of_turn((idx * j) % period, period);
            u   = longint'(acc) + (64'd1 << 61) + (64'd1 << 29);
            res = longint'(u >> 30) - (64'sd1 << 31);
        end
        if (res > gcw_pkg::OUT_MAX) res = gcw_pkg::OUT_MAX;
        if (res < gcw_pkg::OUT_MIN) res = gcw_pkg::OUT_MIN;
        return res[gcw_pkg::OUT_W-1:0];
    endfunction

    // Driver: one word per accepted handshake, valid held until taken.
    always @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            window_expected.push_back(window_at(i_sample_index));
            void'(index_queue.pop_front());
        end
        if (i_in_valid && !o_in_ready) begin
            // hold the pending word
        end else if (index_queue.size() > 0 && !send_hold &&
                     $urandom_range(99) >= send_idle_pct) begin
            i_in_valid     <= 1'b1;
            i_sample_index <= index_queue[0];
        end else begin
            i_in_valid <= 1'b0;
        end
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: every accepted window value is checked against the oldest one.
    always @(posedge i_clk) begin
        logic signed [gcw_pkg::OUT_W-1:0] want;
        cycle_count++;
        if (o_out_valid && i_out_ready) begin
            if (window_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected window value %0d", o_window_value));
            end else begin
                want = window_expected.pop_front();
                if (o_window_value !== want)
                    report_mismatch($sformatf("window_value got %0d want %0d",
                                              o_window_value, want));
            end
        end
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb_generalized_cosine_window_gen_core: done, errors");
            $finish;
        end
    end

    task automatic write_reg(gcw_pkg::t_cfg_reg which, logic [gcw_pkg::COEF_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= which;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (which)
            gcw_pkg::CFG_WINDOW_LENGTH: win_len   = value[12:0];
            gcw_pkg::CFG_SYMMETRIC:     win_sym   = value[0];
            gcw_pkg::CFG_TERM_COUNT:    win_terms = value[2:0];
            default: win_coef[which - gcw_pkg::CFG_COEF_ZERO] = value;
        endcase
    endtask

    // Waits until every queued word is sent and every window value has come.
    task automatic drain();
        while (index_queue.size() != 0 || i_in_valid || window_expected.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic setup(logic [12:0] len, bit sym, logic [2:0] terms,
                         logic [gcw_pkg::COEF_W-1:0] c0, logic [gcw_pkg::COEF_W-1:0] c1,
                         logic [gcw_pkg::COEF_W-1:0] c2, logic [gcw_pkg::COEF_W-1:0] c3,
                         logic [gcw_pkg::COEF_W-1:0] c4);
        write_reg(gcw_pkg::CFG_WINDOW_LENGTH, gcw_pkg::COEF_W'(len));
        write_reg(gcw_pkg::CFG_SYMMETRIC, gcw_pkg::COEF_W'(sym));
        write_reg(gcw_pkg::CFG_TERM_COUNT, gcw_pkg::COEF_W'(terms));
        write_reg(gcw_pkg::CFG_COEF_ZERO, c0);
        write_reg(gcw_pkg::CFG_COEF_ONE, c1);
        write_reg(gcw_pkg::CFG_COEF_TWO, c2);
        write_reg(gcw_pkg::CFG_COEF_THREE, c3);
        write_reg(gcw_pkg::CFG_COEF_FOUR, c4);
    endtask

    // Mostly indices inside the window, some beyond it, some at the extremes.
    task automatic queue_random(int count);
        int kind;
        for (int k = 0; k < count; k++) begin
            kind = $urandom_range(9);
            if (kind < 7 && win_len > 0)
                index_queue.push_back(gcw_pkg::IDX_W'(
                    $urandom_range(((win_len > 4096) ? 4096 : win_len) - 1)));
            else if (kind < 9)
                index_queue.push_back(gcw_pkg::IDX_W'($urandom));
            else
                index_queue.push_back(($urandom_range(1) != 0) ?
                                      {gcw_pkg::IDX_W{1'b1}} : {gcw_pkg::IDX_W{1'b0}});
        end
    endtask

    initial begin
        win_len = gcw_pkg::RST_WINDOW_LENGTH;
        win_sym = gcw_pkg::RST_SYMMETRIC;
        win_terms = gcw_pkg::RST_TERM_COUNT;
        win_coef = '{gcw_pkg::RST_COEF_ZERO, gcw_pkg::RST_COEF_ONE, '0, '0, '0};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset setup (periodic Hann) at index extremes.
        index_queue.push_back(12'd0);
        index_queue.push_back(12'd512);
        index_queue.push_back(12'd1023);
        index_queue.push_back(12'd1024);
        index_queue.push_back(12'hFFF);
        drain();

        // Five-term flattop-like, symmetric, with saturating coefficients.
        setup(13'd4096, 1'b1, 3'd5, 18'h1FFFF, 18'h20000, 18'h1FFFF, 18'h20000, 18'h1FFFF);
        index_queue.push_back(12'd0);
        index_queue.push_back(12'd2047);
        index_queue.push_back(12'd4095);
        index_queue.push_back(12'd1365);
        drain();
        // Length one and length zero give unity.
        setup(13'd1, 1'b0, 3'd3, 18'sd21800, -18'sd32768, 18'sd10968, 18'd0, 18'd0);
        index_queue.push_back(12'd7);
        index_queue.push_back(12'hFFF);
        drain();
        write_reg(gcw_pkg::CFG_WINDOW_LENGTH, 18'd0);
        index_queue.push_back(12'd3);
        drain();
        // Term count zero, above five, lengths above the maximum, length two.
        setup(13'h1FFF, 1'b0, 3'd0, 18'sd65536, 18'd0, 18'd0, 18'd0, 18'd0);
        index_queue.push_back(12'd100);
        drain();
        write_reg(gcw_pkg::CFG_TERM_COUNT, 18'd7);
        index_queue.push_back(12'd100);
        index_queue.push_back(12'd4095);
        drain();
        setup(13'd2, 1'b1, 3'd2, 18'sd32768, -18'sd32768, 18'd0, 18'd0, 18'd0);
        index_queue.push_back(12'd0);
        index_queue.push_back(12'd1);
        index_queue.push_back(12'd2);
        drain();

        // Random phases with varied setups and idling.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            setup((ph == 3) ? 13'd4096 : 13'($urandom_range(2, (ph < 4) ? 64 : 4096)),
                  1'($urandom_range(1)), 3'($urandom_range(7)),
                  gcw_pkg::COEF_W'($urandom), gcw_pkg::COEF_W'($urandom),
                  gcw_pkg::COEF_W'($urandom), gcw_pkg::COEF_W'($urandom),
                  gcw_pkg::COEF_W'($urandom));
            queue_random(55);
            // Hold the sender once until every result is in, then resume.
            while (index_queue.size() > 30) @(posedge i_clk);
            if (ph == 2) begin
                send_hold = 1'b1;
                while (window_expected.size() != 0 || i_in_valid) @(posedge i_clk);
                send_hold = 1'b0;
            end
            queue_random(60);
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("tb_generalized_cosine_window_gen_core: done, clean");
        else
            $display("tb_generalized_cosine_window_gen_core: done, errors");
        $finish;
    end

endmodule
